FILE: hw/rtl/tpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpt_pkg
// Shared widths, register codes and control bundles of the trapezoid tracker.
// ----------------------------------------------------------------------------
package tpt_pkg;

  // tick rate default
  localparam int unsigned TICK_RATE_DEF = 20000;

  // field and state widths
  localparam int POS_W    = 32;
  localparam int SPD_IO_W = 23;
  localparam int SPD_W    = 24;
  localparam int MAXS_W   = 22;
  localparam int ACC_W    = 26;
  localparam int DV_W     = 17;          // divisor width, covers tick rates up to 100000
  localparam int REM_W    = DV_W + 1;    // signed remainder
  localparam int DIV_W    = 28;          // signed dividend of the tick divider
  localparam int DIST_W   = POS_W + 1;
  localparam int SQ_W     = 2 * SPD_W;
  localparam int LO_W     = 17;          // low slice of the distance product
  localparam int PP_W     = LO_W + ACC_W + 1;
  localparam int PROD_W   = DIST_W + ACC_W + 2;

  // config port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_MAX_SPEED  = 2'd0;
  localparam logic [1:0] REG_UP_ACC     = 2'd1;
  localparam logic [1:0] REG_DOWN_ACC   = 2'd2;
  localparam logic [1:0] REG_STOP_SPEED = 2'd3;

  localparam logic [MAXS_W-1:0] MAX_SPEED_RST  = 22'd2560000;
  localparam logic [ACC_W-1:0]  UP_ACC_RST     = 26'd1048576;
  localparam logic [ACC_W-1:0]  DOWN_ACC_RST   = 26'd1048576;
  localparam logic [MAXS_W-1:0] STOP_SPEED_RST = 22'd51200;

  localparam logic signed [SPD_W-1:0] SPD_LIM = 24'sd4194303;

  typedef struct packed {
    logic [MAXS_W-1:0] speed_cap;
    logic [ACC_W-1:0]  up_acc;
    logic [ACC_W-1:0]  brake_acc;
    logic [MAXS_W-1:0] stop_speed;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic delta;
    logic mul_lo;
    logic mul_hi;
    logic accum;
    logic decide;
    logic acc_start;
    logic acc_apply;
    logic pos_start;
    logic pos_apply;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_load;
    logic acc_needed;
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/tpt_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpt_if
// Valid/ready channels for tick requests and commanded results.
// ----------------------------------------------------------------------------
interface tpt_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic signed [31:0]         target_location;
  logic signed [31:0]         start_location;
  logic signed [22:0]         start_speed;

  modport source (output valid, op, target_location, start_location, start_speed,
                  input ready);
  modport sink (input valid, op, target_location, start_location, start_speed,
                output ready);
endinterface

interface tpt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] cmd_location;
  logic signed [22:0] cmd_speed;

  modport source (output valid, cmd_location, cmd_speed, input ready);
  modport sink (input valid, cmd_location, cmd_speed, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/tpt_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpt_regs
// APB register file for speed limit, ramp rates and stop speed.
// ----------------------------------------------------------------------------
module tpt_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tpt_pkg::ADDR_W-1:0]  paddr,
  input  logic [tpt_pkg::DATA_W-1:0]  pwdata,
  output logic [tpt_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output tpt_pkg::cfg_t               cfg
);
  import tpt_pkg::*;

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  // writes; a zero speed limit or zero ramp rate is dropped, a zero stop speed is written
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_cap  <= MAX_SPEED_RST;
      cfg.up_acc     <= UP_ACC_RST;
      cfg.brake_acc  <= DOWN_ACC_RST;
      cfg.stop_speed <= STOP_SPEED_RST;
    end else if (wr) begin
      case (idx)
        REG_MAX_SPEED: begin
          if (pwdata[MAXS_W-1:0] != '0) cfg.speed_cap <= pwdata[MAXS_W-1:0];
        end
        REG_UP_ACC: begin
          if (pwdata[ACC_W-1:0] != '0) cfg.up_acc <= pwdata[ACC_W-1:0];
        end
        REG_DOWN_ACC: begin
          if (pwdata[ACC_W-1:0] != '0) cfg.brake_acc <= pwdata[ACC_W-1:0];
        end
        REG_STOP_SPEED: begin
          cfg.stop_speed <= pwdata[MAXS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_MAX_SPEED:  prdata = DATA_W'(cfg.speed_cap);
      REG_UP_ACC:     prdata = DATA_W'(cfg.up_acc);
      REG_DOWN_ACC:   prdata = DATA_W'(cfg.brake_acc);
      REG_STOP_SPEED: prdata = DATA_W'(cfg.stop_speed);
      default:        prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: hw/rtl/tpt_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpt_div
// Divider by the tick rate: reciprocal multiply, back-multiply and one
// correction step, each registered, with done raised after the correction.
// Quotient and remainder truncate toward zero.
// ----------------------------------------------------------------------------
module tpt_div #(
  parameter int unsigned TICK_RATE = tpt_pkg::TICK_RATE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [tpt_pkg::DIV_W-1:0]  dividend,
  output logic                              done,
  output logic signed [tpt_pkg::DIV_W-1:0]  quo,
  output logic signed [tpt_pkg::REM_W-1:0]  rem
);
  import tpt_pkg::*;

  // floor(2^DIV_W / TICK_RATE); the estimate is low by at most one
  localparam longint unsigned RECIP = (longint'(1) << DIV_W) / longint'(TICK_RATE);
  localparam int RCP_W = $clog2(RECIP + 1);
  localparam int PRD_W = DIV_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP     = RCP_W'(RECIP);
  localparam logic [DIV_W-1:0] DIVISOR = DIV_W'(TICK_RATE);

  logic [4:0]              stage;
  logic                    neg;
  logic [DIV_W-1:0]        mag;
  logic [PRD_W-1:0]        prd;
  logic [RCP_W-1:0]        q0;
  logic [DIV_W-1:0]        r0;
  logic [RCP_W-1:0]        qf;
  logic [DV_W-1:0]         rf;
  logic [DIV_W-1:0]        mag_in;
  logic signed [DIV_W-1:0] q_s;
  logic signed [REM_W-1:0] r_s;

  assign mag_in = dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) stage <= '0;
    else stage <= {stage[3:0], start};
  end

  assign done = stage[4];

  // magnitude, estimate, back-multiply, correction
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[DIV_W-1];
      mag <= mag_in;
    end
    if (stage[0]) prd <= PRD_W'(mag) * PRD_W'(RCP);
    if (stage[1]) q0 <= prd[PRD_W-1:DIV_W];
    if (stage[2]) r0 <= mag - DIV_W'(q0) * DIVISOR;
    if (stage[3]) begin
      if (r0 >= DIVISOR) begin
        qf <= q0 + RCP_W'(1);
        rf <= DV_W'(r0 - DIVISOR);
      end else begin
        qf <= q0;
        rf <= DV_W'(r0);
      end
    end
  end

  assign q_s = $signed(DIV_W'(qf));
  assign r_s = $signed({1'b0, rf});
  assign quo = neg ? -q_s : q_s;
  assign rem = neg ? -r_s : r_s;

endmodule
`default_nettype wire

FILE: hw/rtl/tpt_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpt_dp
// Tracker datapath: motion state, braking-distance test, integrators and
// result register.
// ----------------------------------------------------------------------------
module tpt_dp #(
  parameter int unsigned TICK_RATE = tpt_pkg::TICK_RATE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tpt_pkg::cmd_t                        cmd,
  output tpt_pkg::sts_t                        sts,
  input  tpt_pkg::cfg_t                        cfg,
  input  logic                                 in_op,
  input  logic signed [tpt_pkg::POS_W-1:0]     in_goal,
  input  logic signed [tpt_pkg::POS_W-1:0]     in_start_loc,
  input  logic signed [tpt_pkg::SPD_IO_W-1:0]  in_start_spd,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [tpt_pkg::POS_W-1:0]     out_location,
  output logic signed [tpt_pkg::SPD_IO_W-1:0]  out_speed
);
  import tpt_pkg::*;

  localparam int SPD_X = SPD_W + 1;
  localparam int AC_X  = ACC_W + 1;

  typedef enum logic [1:0] {ACT_NONE, ACT_FREE, ACT_CAP, ACT_BRAKE} act_t;

  // motion state
  logic signed [SPD_W-1:0] speed;
  logic signed [POS_W-1:0] pos;
  logic signed [REM_W-1:0] arem;
  logic signed [REM_W-1:0] srem;

  // latched request
  logic                       op_r;
  logic signed [POS_W-1:0]    goal_r;
  logic signed [POS_W-1:0]    sloc_r;
  logic signed [SPD_IO_W-1:0] sspd_r;

  // per-tick working registers
  logic signed [DIST_W-1:0] delta;
  logic [SQ_W-1:0]          magsq;
  logic [PP_W-1:0]          pp;
  logic [PROD_W-1:0]        prod;
  act_t                     act;
  logic signed [AC_X-1:0]   acc_val;
  logic                     was_pos;

  // combinational
  logic [SPD_W-1:0]        mag;
  logic [DIST_W-1:0]       adist;
  logic [AC_X-1:0]         d2;
  logic [LO_W-1:0]         mul_a;
  logic [SQ_W-1:0]         sq_c;
  logic                    sp_zero, sp_pos, delta_zero, delta_pos, far;
  logic signed [AC_X-1:0]  up_s, dn_s;
  act_t                    act_c;
  logic signed [AC_X-1:0]  acc_c;
  logic                    snap_c, brk_c;
  logic                    div_start, div_done;
  logic signed [DIV_W-1:0] dvd, quo;
  logic signed [REM_W-1:0] drem;
  logic signed [SPD_X-1:0] spd_sum, mx_s;
  logic signed [SPD_IO_W-1:0] sat_c;

  assign mag     = speed[SPD_W-1] ? SPD_W'(-speed) : SPD_W'(speed);
  assign adist   = delta[DIST_W-1] ? DIST_W'(-delta) : DIST_W'(delta);
  assign d2      = {cfg.brake_acc, 1'b0};
  assign mul_a   = cmd.mul_hi ? LO_W'(adist[DIST_W-1:LO_W]) : adist[LO_W-1:0];
  assign sq_c    = mag * mag;
  assign sp_zero = (speed == '0);
  assign sp_pos  = !speed[SPD_W-1] && !sp_zero;
  assign delta_zero = (delta == '0);
  assign delta_pos  = !delta[DIST_W-1] && !delta_zero;
  // remaining distance beats floor(v*v / (2*brake_acc)) exactly when v*v < dist*2*brake_acc
  assign far     = PROD_W'(magsq) < prod;
  assign up_s    = $signed({1'b0, cfg.up_acc});
  assign dn_s    = $signed({1'b0, cfg.brake_acc});
  assign mx_s    = $signed(SPD_X'(cfg.speed_cap));

  // tick decision
  always_comb begin
    act_c  = ACT_NONE;
    acc_c  = '0;
    snap_c = 1'b0;
    brk_c  = 1'b0;
    if (delta_zero) begin
      if (mag <= SPD_W'(cfg.stop_speed)) snap_c = 1'b1;
      else brk_c = 1'b1;
    end else if (sp_zero) begin
      act_c = ACT_FREE;
      acc_c = delta_pos ? up_s : -up_s;
    end else if (delta_pos == sp_pos) begin
      if (mag <= SPD_W'(cfg.speed_cap)) begin
        if (far) begin
          if (mag < SPD_W'(cfg.speed_cap)) begin
            act_c = ACT_CAP;
            acc_c = sp_pos ? up_s : -up_s;
          end
        end else begin
          brk_c = 1'b1;
        end
      end else begin
        brk_c = 1'b1;
      end
    end else begin
      brk_c = 1'b1;
    end
    if (brk_c && !sp_zero) begin
      act_c = ACT_BRAKE;
      acc_c = sp_pos ? -dn_s : dn_s;
    end
  end

  // shared divider by the tick rate
  assign div_start = cmd.acc_start || cmd.pos_start;
  assign dvd = cmd.acc_start ? DIV_W'(arem) + DIV_W'(acc_val)
                             : DIV_W'(srem) + DIV_W'(speed);

  tpt_div #(.TICK_RATE(TICK_RATE)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd),
    .done     (div_done),
    .quo      (quo),
    .rem      (drem)
  );

  assign spd_sum = SPD_X'(speed) + SPD_X'(quo);

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_op;
      goal_r <= in_goal;
      sloc_r <= in_start_loc;
      sspd_r <= in_start_spd;
    end
  end

  // distance test operands
  always_ff @(posedge clk) begin
    if (cmd.delta) begin
      delta <= DIST_W'(goal_r) - DIST_W'(pos);
      magsq <= sq_c;
    end
    if (cmd.mul_lo || cmd.mul_hi) pp <= PP_W'(mul_a * d2);
    if (cmd.mul_hi) prod <= PROD_W'(pp);
    if (cmd.accum) prod <= prod + (PROD_W'(pp) << LO_W);
    if (cmd.decide) begin
      act     <= act_c;
      acc_val <= acc_c;
      was_pos <= sp_pos;
    end
  end

  // motion state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      speed <= '0;
      pos   <= '0;
      arem  <= '0;
      srem  <= '0;
    end else if (cmd.load) begin
      speed <= SPD_W'(sspd_r);
      pos   <= sloc_r;
      arem  <= '0;
      srem  <= '0;
    end else if (cmd.decide && snap_c) begin
      speed <= '0;
      arem  <= '0;
      srem  <= '0;
    end else if (cmd.acc_apply) begin
      speed <= spd_sum[SPD_W-1:0];
      arem  <= drem;
      case (act)
        ACT_BRAKE: begin
          if (was_pos ? (spd_sum <= 0) : (spd_sum >= 0)) begin
            speed <= '0;
            arem  <= '0;
          end
        end
        ACT_CAP: begin
          if (was_pos ? (spd_sum >= mx_s) : (spd_sum <= -mx_s)) begin
            speed <= was_pos ? mx_s[SPD_W-1:0] : SPD_W'(-mx_s);
            arem  <= '0;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.pos_apply) begin
      pos  <= pos + POS_W'(quo);
      srem <= drem;
    end
  end

  // output saturation
  always_comb begin
    if (speed > SPD_LIM) sat_c = SPD_LIM[SPD_IO_W-1:0];
    else if (speed < -SPD_LIM) sat_c = SPD_IO_W'(-SPD_LIM);
    else sat_c = speed[SPD_IO_W-1:0];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_location <= pos;
      out_speed    <= sat_c;
    end
  end

  assign sts.is_load    = op_r;
  assign sts.acc_needed = (act != ACT_NONE);
  assign sts.div_done   = div_done;
  assign sts.out_busy   = out_valid && !out_ready;

endmodule
`default_nettype wire

FILE: hw/rtl/tpt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpt_ctrl
// Sequencer for one request: a load, or distance test, acceleration step, position step.
// ----------------------------------------------------------------------------
module tpt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  tpt_pkg::sts_t sts,
  output tpt_pkg::cmd_t cmd
);
  import tpt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_MUL_LO, S_MUL_HI, S_ACCUM, S_DECIDE, S_ACC_CHK,
    S_ACC_WAIT, S_POS_START, S_POS_WAIT, S_FINISH
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_load) begin
          cmd.load   = 1'b1;
          state_next = S_FINISH;
        end else begin
          cmd.delta  = 1'b1;
          state_next = S_MUL_LO;
        end
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_ACCUM;
      end
      S_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = S_ACC_CHK;
      end
      S_ACC_CHK: begin
        if (sts.acc_needed) begin
          cmd.acc_start = 1'b1;
          state_next    = S_ACC_WAIT;
        end else begin
          state_next = S_POS_START;
        end
      end
      S_ACC_WAIT: begin
        if (sts.div_done) begin
          cmd.acc_apply = 1'b1;
          state_next    = S_POS_START;
        end
      end
      S_POS_START: begin
        cmd.pos_start = 1'b1;
        state_next    = S_POS_WAIT;
      end
      S_POS_WAIT: begin
        if (sts.div_done) begin
          cmd.pos_apply = 1'b1;
          state_next    = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/trapezoid_position_tracker_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trapezoid_position_tracker_core
// Trapezoidal motion profile: one commanded position and speed per request.
//
//   channel   dir   handshake       payload
//   tick_in   in    valid/ready     op, target_location, start_location, start_speed
//   cmd_out   out   valid/ready     cmd_location, cmd_speed
//   apb       in    psel/penable    paddr[3:2] register, pwdata, prdata
//
// A tick runs the distance test and decision, then two divisions by TICK_RATE
// for the acceleration step and the position step, each started and then
// applied by the sequencer. A tick with no acceleration step skips the first
// division, and a load skips both. One request is in flight at a time; the next
// is accepted in the cycle after the result is loaded, and the result register
// stalls the sequencer only while it still holds an unaccepted result. Reset is
// synchronous and clears the motion state and registers to their defaults.
// ----------------------------------------------------------------------------
module trapezoid_position_tracker_core #(
  parameter int unsigned TICK_RATE = tpt_pkg::TICK_RATE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  tpt_in_if.sink                      tick_in,
  tpt_out_if.source                   cmd_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tpt_pkg::ADDR_W-1:0]  paddr,
  input  logic [tpt_pkg::DATA_W-1:0]  pwdata,
  output logic [tpt_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import tpt_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  tpt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (tick_in.valid),
    .in_ready (tick_in.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tpt_dp #(.TICK_RATE(TICK_RATE)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg          (cfg),
    .in_op        (tick_in.op),
    .in_goal      (tick_in.target_location),
    .in_start_loc (tick_in.start_location),
    .in_start_spd (tick_in.start_speed),
    .out_valid    (cmd_out.valid),
    .out_ready    (cmd_out.ready),
    .out_location (cmd_out.cmd_location),
    .out_speed    (cmd_out.cmd_speed)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/tpt_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpt_check
// Port-level checks of the tracker, bound to the top level.
// ----------------------------------------------------------------------------
module tpt_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] cmd_location,
  input logic [22:0] cmd_speed
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cmd_location) && $stable(cmd_speed))
    else $error("result changed while stalled");

  // after reset: idle and empty
  a_reset: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // speed stays inside the symmetric limit
  a_speed_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cmd_speed != 23'h400000)
    else $error("speed outside limit");

endmodule

bind trapezoid_position_tracker_core tpt_check u_check (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (tick_in.valid),
  .in_ready     (tick_in.ready),
  .out_valid    (cmd_out.valid),
  .out_ready    (cmd_out.ready),
  .cmd_location (cmd_out.cmd_location),
  .cmd_speed    (cmd_out.cmd_speed)
);
`default_nettype wire
